[rtl/rau_pkg.sv]
package rau_pkg;

  // Datapath width of all internal arithmetic
  localparam int DATA_W = 64;
  // Width of each operand field on the input channel
  localparam int IN_W = 32;
  // Default number of significant operand bits
  localparam int OPERAND_BITS_DEF = 32;
  localparam int KIND_W = 3;

  // Operation codes
  localparam logic [KIND_W-1:0] KIND_ADD  = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DIV  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SIMP = 3'd4;

  // Request and response of the shared divider
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } div_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] q;
    logic [DATA_W-1:0] r;
  } div_rsp_t;

  // Request and response of the shared multiplier
  typedef struct packed {
    logic              start;
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] p;
  } mul_rsp_t;

endpackage

[rtl/rau_if.sv]
interface rau_in_if;
  import rau_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [KIND_W-1:0]       kind;
  logic signed [IN_W-1:0]  num_a;
  logic signed [IN_W-1:0]  den_a;
  logic signed [IN_W-1:0]  num_b;
  logic signed [IN_W-1:0]  den_b;

  modport source (output valid, kind, num_a, den_a, num_b, den_b, input ready);
  modport sink (input valid, kind, num_a, den_a, num_b, den_b, output ready);
endinterface

interface rau_out_if;
  import rau_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DATA_W-1:0] res_num;
  logic signed [DATA_W-1:0] res_den;
  logic                     fault;

  modport source (output valid, res_num, res_den, fault, input ready);
  modport sink (input valid, res_num, res_den, fault, output ready);
endinterface

[rtl/rau_div.sv]
module rau_div (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::div_req_t  req,
  output rau_pkg::div_rsp_t  rsp
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W-1:0] q_r;
  logic [DATA_W-1:0] rem_r;
  logic [DATA_W-1:0] mb_r;
  logic              neg_q_r;
  logic              neg_r_r;

  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  // One restoring step per cycle
  assign shifted = {rem_r, q_r[DATA_W-1]};
  assign diff    = shifted - {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r  <= 1'b1;
        cnt_r   <= CNT_W'(DATA_W);
        q_r     <= req.a[DATA_W-1] ? -req.a : req.a;
        mb_r    <= req.b[DATA_W-1] ? -req.b : req.b;
        rem_r   <= '0;
        neg_q_r <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
        neg_r_r <= req.a[DATA_W-1];
      end else if (busy_r) begin
        if (!diff[DATA_W]) begin
          rem_r <= diff[DATA_W-1:0];
        end else begin
          rem_r <= shifted[DATA_W-1:0];
        end
        q_r   <= {q_r[DATA_W-2:0], ~diff[DATA_W]};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // Sign fix-up: truncating quotient, remainder takes the dividend's sign
  assign rsp.done = done_r;
  assign rsp.q    = neg_q_r ? -q_r : q_r;
  assign rsp.r    = neg_r_r ? -rem_r : rem_r;

endmodule

[rtl/rau_mul.sv]
module rau_mul (
  input  logic               clk,
  input  logic               rst_n,
  input  rau_pkg::mul_req_t  req,
  output rau_pkg::mul_rsp_t  rsp
);
  import rau_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [DATA_W-1:0] acc_r;
  logic [DATA_W-1:0] mcand_r;
  logic [DATA_W-1:0] mplier_r;

  // Shift-add, one multiplier bit per cycle, low word kept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r   <= 1'b1;
        cnt_r    <= CNT_W'(DATA_W);
        acc_r    <= '0;
        mcand_r  <= req.a;
        mplier_r <= req.b;
      end else if (busy_r) begin
        if (mplier_r[0]) begin
          acc_r <= acc_r + mcand_r;
        end
        mcand_r  <= {mcand_r[DATA_W-2:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[DATA_W-1:1]};
        cnt_r    <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.p    = acc_r;

endmodule

[rtl/rational_arithmetic_unit.sv]
// Rational arithmetic unit: one transaction carries an operation (add, subtract,
// multiply, divide, simplify a) on two fractions and returns one fraction plus a
// fault flag; results wrap at 64 bits. Work runs on one shared restoring divider
// and one shared shift-add multiplier under a small sequencer. Multiply and
// divide take two multiplier calls. Add and subtract take one divider call per
// Euclid step of gcd(den_a, den_b), then one multiply, three divides and two
// multiplies. Simplify takes the Euclid steps plus two divides; it makes no unit
// call when num_a is 0 or 1 and skips the divides when the gcd is 1. in_ch.ready
// is high only while the unit is idle.
module rational_arithmetic_unit #(
  parameter int OPERAND_BITS = rau_pkg::OPERAND_BITS_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  rau_in_if.sink    in_ch,
  rau_out_if.source out_ch
);
  import rau_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD, ST_PROD, ST_LCM, ST_M1, ST_M2, ST_P1, ST_P2,
    ST_MUL_N, ST_MUL_D, ST_SIMP_N, ST_SIMP_D, ST_OUT
  } state_t;

  state_t            state_r;
  logic              launched_r;
  logic [KIND_W-1:0] kind_r;
  logic [DATA_W-1:0] na_r, da_r, nb_r, db_r;
  logic [DATA_W-1:0] a_r, b_r, g_r, lcm_r, m1_r, m2_r, p1_r;
  logic [DATA_W-1:0] rn_r, rd_r;
  logic              fault_r;

  div_req_t          div_req;
  div_rsp_t          div_rsp;
  mul_req_t          mul_req;
  mul_rsp_t          mul_rsp;

  logic              use_div, use_mul, div_zero, step_fire;
  logic [DATA_W-1:0] step_val;
  logic [DATA_W-1:0] in_na, in_da, in_nb, in_db;
  logic              in_acc;

  function automatic logic [DATA_W-1:0] sext(input logic [IN_W-1:0] v);
    return {{(DATA_W-OPERAND_BITS){v[OPERAND_BITS-1]}}, v[OPERAND_BITS-1:0]};
  endfunction

  assign in_na  = sext(in_ch.num_a);
  assign in_da  = sext(in_ch.den_a);
  assign in_nb  = sext(in_ch.num_b);
  assign in_db  = sext(in_ch.den_b);
  assign in_acc = in_ch.valid && in_ch.ready;

  rau_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .rsp(div_rsp));
  rau_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mul_req), .rsp(mul_rsp));

  // Operand routing to the shared units per step
  always_comb begin
    use_div   = 1'b0;
    use_mul   = 1'b0;
    div_req.a = lcm_r;
    div_req.b = g_r;
    mul_req.a = na_r;
    mul_req.b = nb_r;
    case (state_r)
      ST_GCD: begin
        use_div   = (b_r != '0);
        div_req.a = a_r;
        div_req.b = b_r;
      end
      ST_PROD: begin
        use_mul   = 1'b1;
        mul_req.a = da_r;
        mul_req.b = db_r;
      end
      ST_LCM:  use_div = 1'b1;
      ST_M1: begin
        use_div   = 1'b1;
        div_req.b = da_r;
      end
      ST_M2: begin
        use_div   = 1'b1;
        div_req.b = db_r;
      end
      ST_P1: begin
        use_mul   = 1'b1;
        mul_req.b = m1_r;
      end
      ST_P2: begin
        use_mul   = 1'b1;
        mul_req.a = nb_r;
        mul_req.b = m2_r;
      end
      ST_MUL_N: begin
        use_mul   = 1'b1;
        mul_req.b = (kind_r == KIND_MUL) ? nb_r : db_r;
      end
      ST_MUL_D: begin
        use_mul   = 1'b1;
        mul_req.a = da_r;
        mul_req.b = (kind_r == KIND_MUL) ? db_r : nb_r;
      end
      ST_SIMP_N: begin
        use_div   = 1'b1;
        div_req.a = na_r;
      end
      ST_SIMP_D: begin
        use_div   = 1'b1;
        div_req.a = da_r;
      end
      default: ;
    endcase
    div_zero      = use_div && (div_req.b == '0);
    div_req.start = use_div && !launched_r && !div_zero;
    mul_req.start = use_mul && !launched_r;
    step_fire     = div_zero ||
                    (launched_r && (use_div ? div_rsp.done : mul_rsp.done));
    step_val      = div_zero ? '0 : (use_div ? div_rsp.q : mul_rsp.p);
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      launched_r <= 1'b0;
      fault_r    <= 1'b0;
    end else begin
      if (div_req.start || mul_req.start) begin
        launched_r <= 1'b1;
      end
      if (step_fire) begin
        launched_r <= 1'b0;
      end
      if (div_zero) begin
        fault_r <= 1'b1;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            kind_r  <= in_ch.kind;
            na_r    <= in_na;
            da_r    <= in_da;
            nb_r    <= in_nb;
            db_r    <= in_db;
            fault_r <= 1'b0;
            case (in_ch.kind)
              KIND_ADD, KIND_SUB: begin
                a_r     <= in_da;
                b_r     <= in_db;
                state_r <= ST_GCD;
              end
              KIND_MUL, KIND_DIV: state_r <= ST_MUL_N;
              KIND_SIMP: begin
                rn_r <= in_na;
                rd_r <= in_da;
                if (in_na == '0 || in_na == DATA_W'(1)) begin
                  state_r <= ST_OUT;
                end else begin
                  a_r <= (in_na[DATA_W-1] && !in_da[DATA_W-1] && in_da != '0) ?
                         -in_na : in_na;
                  b_r     <= in_da;
                  state_r <= ST_GCD;
                end
              end
              default: begin
                rn_r    <= '0;
                rd_r    <= '0;
                state_r <= ST_OUT;
              end
            endcase
          end
        end
        ST_GCD: begin
          if (b_r == '0) begin
            g_r <= a_r;
            if (kind_r != KIND_SIMP) begin
              state_r <= ST_PROD;
            end else if (a_r == DATA_W'(1)) begin
              state_r <= ST_OUT;
            end else begin
              state_r <= ST_SIMP_N;
            end
          end else if (step_fire) begin
            a_r <= b_r;
            b_r <= div_rsp.r;
          end
        end
        ST_PROD: if (step_fire) begin
          lcm_r   <= step_val;
          state_r <= ST_LCM;
        end
        ST_LCM: if (step_fire) begin
          lcm_r   <= step_val;
          state_r <= ST_M1;
        end
        ST_M1: if (step_fire) begin
          m1_r    <= step_val;
          state_r <= ST_M2;
        end
        ST_M2: if (step_fire) begin
          m2_r    <= step_val;
          state_r <= ST_P1;
        end
        ST_P1: if (step_fire) begin
          p1_r    <= step_val;
          state_r <= ST_P2;
        end
        ST_P2: if (step_fire) begin
          rn_r    <= (kind_r == KIND_ADD) ? p1_r + step_val : p1_r - step_val;
          rd_r    <= lcm_r;
          state_r <= ST_OUT;
        end
        ST_MUL_N: if (step_fire) begin
          rn_r    <= step_val;
          state_r <= ST_MUL_D;
        end
        ST_MUL_D: if (step_fire) begin
          rd_r    <= step_val;
          state_r <= ST_OUT;
        end
        ST_SIMP_N: if (step_fire) begin
          rn_r    <= step_val;
          state_r <= ST_SIMP_D;
        end
        ST_SIMP_D: if (step_fire) begin
          rd_r    <= step_val;
          state_r <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Channel outputs; a fault forces a zero fraction
  assign in_ch.ready    = (state_r == ST_IDLE);
  assign out_ch.valid   = (state_r == ST_OUT);
  assign out_ch.res_num = fault_r ? '0 : rn_r;
  assign out_ch.res_den = fault_r ? '0 : rd_r;
  assign out_ch.fault   = fault_r;

  // Never take new work while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ch.ready && out_ch.valid)) else $error("ready while result pending");

  // Divider never launched with a zero divisor
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    div_req.start |-> div_req.b != '0) else $error("divider started on zero");

  // Only one shared unit launched per cycle
  a_one_unit: assert property (@(posedge clk) disable iff (!rst_n)
    !(div_req.start && mul_req.start)) else $error("both units started");

  // A unit result only arrives while a launch is outstanding
  a_done_launched: assert property (@(posedge clk) disable iff (!rst_n)
    (div_rsp.done || mul_rsp.done) |-> launched_r) else $error("stray unit done");

endmodule

[sim/rational_arithmetic_unit_tb.sv]
module rational_arithmetic_unit_tb;
  import rau_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [KIND_W-1:0] kind;
    logic [IN_W-1:0]   num_a;
    logic [IN_W-1:0]   den_a;
    logic [IN_W-1:0]   num_b;
    logic [IN_W-1:0]   den_b;
  } op_item_t;

  typedef struct {
    logic [DATA_W-1:0] res_num;
    logic [DATA_W-1:0] res_den;
    logic              fault;
  } fraction_t;

  localparam logic [IN_W-1:0] MIN_VAL = 32'h8000_0000;
  localparam logic [IN_W-1:0] MAX_VAL = 32'h7fff_ffff;
  localparam logic [IN_W-1:0] NEG_ONE = 32'hffff_ffff;

  logic clk;
  logic rst_n;
  rau_in_if  in_ch();
  rau_out_if out_ch();

  rational_arithmetic_unit uut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  fraction_t pending_fractions[$];
  int        errors = 0;
  int        sent = 0;
  int        received = 0;
  int        kind_count[8];
  bit        idle_on = 0;
  bit        sink_hold = 0;
  int        sink_stall = 0;

  // 20 ns clock
  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // --- prediction ---
  function automatic logic [DATA_W-1:0] sx(logic [IN_W-1:0] v);
    return {{(DATA_W-IN_W){v[IN_W-1]}}, v};
  endfunction

  function automatic logic [DATA_W-1:0] magnitude(logic [DATA_W-1:0] x);
    return x[DATA_W-1] ? -x : x;
  endfunction

  // truncating remainder, sign follows the dividend
  function automatic logic [DATA_W-1:0] trunc_rem(logic [DATA_W-1:0] a,
                                                  logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] r;
    r = magnitude(a) % magnitude(b);
    return a[DATA_W-1] ? -r : r;
  endfunction

  function automatic logic [DATA_W-1:0] trunc_div(logic [DATA_W-1:0] a,
                                                  logic [DATA_W-1:0] b,
                                                  inout logic flt);
    logic [DATA_W-1:0] q;
    if (b == 0) begin
      flt = 1'b1;
      return '0;
    end
    q = magnitude(a) / magnitude(b);
    return (a[DATA_W-1] != b[DATA_W-1]) ? -q : q;
  endfunction

  function automatic logic [DATA_W-1:0] euclid_gcd(logic [DATA_W-1:0] a,
                                                   logic [DATA_W-1:0] b);
    logic [DATA_W-1:0] t;
    while (b != 0) begin
      t = b;
      b = trunc_rem(a, b);
      a = t;
    end
    return a;
  endfunction

  function automatic fraction_t compute_fraction(op_item_t op);
    fraction_t f;
    logic [DATA_W-1:0] na, da, nb, db, g, lcm, m1, m2;
    logic flt;
    na = sx(op.num_a);
    da = sx(op.den_a);
    nb = sx(op.num_b);
    db = sx(op.den_b);
    flt = 1'b0;
    f.res_num = '0;
    f.res_den = '0;
    case (op.kind)
      KIND_ADD, KIND_SUB: begin
        g   = euclid_gcd(da, db);
        lcm = trunc_div(da * db, g, flt);
        m1  = trunc_div(lcm, da, flt);
        m2  = trunc_div(lcm, db, flt);
        f.res_num = (op.kind == KIND_ADD) ? na * m1 + nb * m2 : na * m1 - nb * m2;
        f.res_den = lcm;
      end
      KIND_MUL: begin
        f.res_num = na * nb;
        f.res_den = da * db;
      end
      KIND_DIV: begin
        f.res_num = na * db;
        f.res_den = da * nb;
      end
      KIND_SIMP: begin
        f.res_num = na;
        f.res_den = da;
        if (na != 0 && na != 1) begin
          if (na[DATA_W-1] && !da[DATA_W-1] && da != 0) g = euclid_gcd(-na, da);
          else g = euclid_gcd(na, da);
          if (g != 1) begin
            f.res_num = trunc_div(na, g, flt);
            f.res_den = trunc_div(da, g, flt);
          end
        end
      end
      default: ;
    endcase
    if (flt) begin
      f.res_num = '0;
      f.res_den = '0;
    end
    f.fault = flt;
    return f;
  endfunction

  // --- result side: ready with random stall bursts, or a long hold ---
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b1;
    end else if (sink_hold) begin
      out_ch.ready = 1'b0;
    end else if (sink_stall > 0) begin
      out_ch.ready = 1'b0;
      sink_stall--;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_ch.ready = 1'b0;
      sink_stall = $urandom_range(1, 14) - 1;
    end else begin
      out_ch.ready = 1'b1;
    end
  end

  // compare each result transaction with the oldest prediction
  always @(posedge clk) begin
    fraction_t exp_f;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      received++;
      if (pending_fractions.size() == 0) begin
        $error("unexpected result: num=%h den=%h fault=%b",
               out_ch.res_num, out_ch.res_den, out_ch.fault);
        errors++;
      end else begin
        exp_f = pending_fractions.pop_front();
        if (out_ch.res_num !== exp_f.res_num) begin
          $error("res_num: expected %h, got %h", exp_f.res_num, out_ch.res_num);
          errors++;
        end
        if (out_ch.res_den !== exp_f.res_den) begin
          $error("res_den: expected %h, got %h", exp_f.res_den, out_ch.res_den);
          errors++;
        end
        if (out_ch.fault !== exp_f.fault) begin
          $error("fault: expected %b, got %b", exp_f.fault, out_ch.fault);
          errors++;
        end
      end
    end
  end

  // --- input side ---
  task automatic send_op(op_item_t op);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.kind  = op.kind;
    in_ch.num_a = op.num_a;
    in_ch.den_a = op.den_a;
    in_ch.num_b = op.num_b;
    in_ch.den_b = op.den_b;
    do @(posedge clk); while (!in_ch.ready);
    pending_fractions.push_back(compute_fraction(op));
    sent++;
    kind_count[op.kind]++;
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  function automatic op_item_t make_op(logic [KIND_W-1:0] k, logic [IN_W-1:0] na,
                                       logic [IN_W-1:0] da, logic [IN_W-1:0] nb,
                                       logic [IN_W-1:0] db);
    op_item_t op;
    op.kind = k;
    op.num_a = na;
    op.den_a = da;
    op.num_b = nb;
    op.den_b = db;
    return op;
  endfunction

  // mostly small operands keep Euclid short; some full-width values
  function automatic logic [IN_W-1:0] rand_operand();
    case ($urandom_range(0, 9))
      0, 1:    return $urandom();
      2:       return MIN_VAL | $urandom_range(0, 3);
      3:       return MAX_VAL - $urandom_range(0, 3);
      4:       return $urandom_range(0, 2);
      default: return $urandom_range(0, 400) - 200;
    endcase
  endfunction

  function automatic op_item_t rand_op();
    logic [KIND_W-1:0] k;
    if ($urandom_range(0, 19) == 0) k = KIND_W'($urandom_range(5, 7));
    else k = KIND_W'($urandom_range(0, 4));
    return make_op(k, rand_operand(), rand_operand(), rand_operand(), rand_operand());
  endfunction

  // --- tests ---
  task automatic test_directed();
    send_op(make_op(KIND_ADD,  1, 2, 1, 3));
    send_op(make_op(KIND_SUB,  1, 2, 1, 3));
    send_op(make_op(KIND_MUL,  3, 4, 5, 7));
    send_op(make_op(KIND_DIV,  3, 4, 5, 7));
    send_op(make_op(KIND_SIMP, 6, 8, 0, 0));
    // zero denominators fault in add and subtract, but not in simplify
    send_op(make_op(KIND_ADD,  1, 0, 1, 0));
    send_op(make_op(KIND_SUB,  5, 0, 3, 7));
    send_op(make_op(KIND_SIMP, 0, 0, 0, 0));
    send_op(make_op(KIND_SIMP, 4, 0, 0, 0));
    // simplify leaves numerator zero or one untouched
    send_op(make_op(KIND_SIMP, 0, 9, 0, 0));
    send_op(make_op(KIND_SIMP, 1, 9, 0, 0));
    // negative numerator over positive denominator
    send_op(make_op(KIND_SIMP, -32'sd12, 18, 0, 0));
    // coprime: unchanged
    send_op(make_op(KIND_SIMP, 7, 9, 0, 0));
    // most negative by minus one
    send_op(make_op(KIND_SIMP, MIN_VAL, NEG_ONE, 0, 0));
    send_op(make_op(KIND_ADD,  MIN_VAL, NEG_ONE, MAX_VAL, NEG_ONE));
    // multiply and divide with zero denominators never fault
    send_op(make_op(KIND_MUL,  MAX_VAL, 0, MAX_VAL, 0));
    send_op(make_op(KIND_DIV,  MIN_VAL, MIN_VAL, 0, MIN_VAL));
    // extremes
    send_op(make_op(KIND_ADD,  MAX_VAL, MAX_VAL, MIN_VAL, MIN_VAL));
    send_op(make_op(KIND_SUB,  MIN_VAL, MAX_VAL, MAX_VAL, MIN_VAL));
    send_op(make_op(KIND_MUL,  MIN_VAL, MIN_VAL, MIN_VAL, MIN_VAL));
    send_op(make_op(KIND_SIMP, MIN_VAL, MIN_VAL, 0, 0));
    // unused codes
    send_op(make_op(3'd5, 1, 2, 3, 4));
    send_op(make_op(3'd6, MAX_VAL, 2, 3, 4));
    send_op(make_op(3'd7, NEG_ONE, NEG_ONE, NEG_ONE, NEG_ONE));
  endtask

  task automatic test_random(int count);
    idle_on = 1;
    repeat (count) send_op(rand_op());
  endtask

  task automatic test_backpressure();
    idle_on = 0;
    fork
      begin
        sink_hold = 1;
        repeat (4000) @(negedge clk);
        sink_hold = 0;
      end
      repeat (20) send_op(rand_op());
    join
  endtask

  task automatic test_no_idle(int count);
    idle_on = 0;
    repeat (count) send_op(rand_op());
  endtask

  initial begin
    rst_n = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.kind  = '0;
    in_ch.num_a = '0;
    in_ch.den_a = '0;
    in_ch.num_b = '0;
    in_ch.den_b = '0;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_random(1500);
    test_backpressure();
    test_no_idle(300);

    wait (pending_fractions.size() == 0);
    repeat (200) @(posedge clk);
    $display("Sent %0d operations (add %0d, sub %0d, mul %0d, div %0d, simplify %0d)",
             sent, kind_count[0], kind_count[1], kind_count[2], kind_count[3],
             kind_count[4]);
    $display("Checked %0d results, %0d mismatches, with random stalls and a long hold",
             received, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // watchdog
  initial begin
    #600ms;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

[files.f]
rtl/rau_pkg.sv
rtl/rau_if.sv
rtl/rau_div.sv
rtl/rau_mul.sv
rtl/rational_arithmetic_unit.sv
sim/rational_arithmetic_unit_tb.sv
